FILE: rtl/compare_match_timer_regs_assert.svh
// Assertion macros shared by the compare-match timer RTL.
`ifndef COMPARE_MATCH_TIMER_REGS_ASSERT_SVH
`define COMPARE_MATCH_TIMER_REGS_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside of reset.
`define CMT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define CMT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMT_ASSERT(lbl, prop, msg)
`define CMT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/cmt_pkg.sv
// Types and constants shared by the compare-match timer modules.
`timescale 1ns / 1ps
package cmt_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned REG_W    = 32;
	localparam int unsigned TIME_W   = 64;
	localparam int unsigned CTRL_W   = 2;
	localparam int unsigned FLAG_W   = 4;
	localparam int unsigned CTRL_EN_BIT = 0;

	// One count per microsecond of input time.
	localparam int unsigned TICK_NS  = 1000;
	localparam int unsigned REM_W    = $clog2(TICK_NS);

	// The divide by TICK_NS runs one sixteen-bit digit per stage.
	localparam int unsigned DIV_STEP_BITS = 16;
	localparam int unsigned DIV_STAGES    = TIME_W / DIV_STEP_BITS;
	// A digit step divides the remainder joined with the next digit, which stays below
	// TICK_NS << DIV_STEP_BITS. The reciprocal is rounded up and is exact over that range.
	localparam int unsigned TRIAL_W     = REM_W + DIV_STEP_BITS;
	localparam int unsigned RECIP_SHIFT = TRIAL_W + REM_W;
	localparam int unsigned RECIP_W     = 27;
	localparam int unsigned PROD_W      = TRIAL_W + RECIP_W;
	localparam logic [RECIP_W-1:0] TICK_RECIP = 27'd68719477;
	localparam logic [TRIAL_W-1:0] TICK_TRIAL = TRIAL_W'(TICK_NS);

	localparam logic [TIME_W-1:0] CMP_DISARMED = '1;
	localparam logic [CTRL_W-1:0] CTRL_RESET   = CTRL_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_CNT_LO   = 4'd0,
		REG_CNT_HI   = 4'd1,
		REG_CFG      = 4'd2,
		REG_INT_STAT = 4'd3,
		REG_INT_EN   = 4'd4,
		REG_CMP0_LO  = 4'd5,
		REG_CMP0_HI  = 4'd6,
		REG_CMP1_LO  = 4'd7,
		REG_CMP1_HI  = 4'd8,
		REG_CMP2_LO  = 4'd9,
		REG_CMP2_HI  = 4'd10,
		REG_CMP3_LO  = 4'd11,
		REG_CMP3_HI  = 4'd12,
		REG_STAT     = 4'd13
	} reg_idx_t;

	// One item as it travels down the pipeline.
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic [REG_W-1:0] data;
		logic             adv;
		logic [REG_W-1:0] rd;
	} item_t;

	// Division state: dividend bits shift out at the top while quotient bits shift in below.
	typedef struct packed {
		logic [TIME_W-1:0] dq;
		logic [REM_W-1:0]  rem;
	} div_t;

endpackage

FILE: rtl/cmt_front.sv
// Front stage: tick decision, timestamp and configuration state.
`timescale 1ns / 1ps
`include "compare_match_timer_regs_assert.svh"
module cmt_front import cmt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   operation,
	input  logic [IDX_W-1:0]  reg_index,
	input  logic [REG_W-1:0]  write_data,
	input  logic [TIME_W-1:0] now_ns,
	output logic              s_valid,
	input  logic              s_ready,
	output item_t             s_item,
	output div_t              s_div
);

	logic              accept;
	logic              tick_en;
	logic              advance;
	logic [TIME_W-1:0] elapsed;
	logic [CTRL_W-1:0] ctrl_q;
	logic              time_valid_q;
	logic [TIME_W-1:0] last_time_q;
	logic              valid_s1;
	item_t             item_s1;
	div_t              div_s1;
	item_t             item_d;

	assign in_ready = !valid_s1 || s_ready;
	assign accept   = in_valid && in_ready;
	assign elapsed  = now_ns - last_time_q;
	assign tick_en  = (operation == OP_TICK) && ctrl_q[CTRL_EN_BIT];
	assign advance  = tick_en && time_valid_q && (elapsed >= TIME_W'(TICK_NS));

	always_comb begin
		item_d.op   = operation;
		item_d.idx  = reg_index;
		item_d.data = write_data;
		item_d.adv  = advance;
		item_d.rd   = '0;
		if ((operation == OP_READ) && (reg_index == REG_CFG)) begin
			item_d.rd = REG_W'(ctrl_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q       <= CTRL_RESET;
			time_valid_q <= 1'b0;
			last_time_q  <= '0;
		end else if (accept) begin
			if (tick_en && !time_valid_q) begin
				time_valid_q <= 1'b1;
				last_time_q  <= now_ns;
			end else if (advance) begin
				last_time_q  <= now_ns;
			end
			if ((operation == OP_WRITE) && (reg_index == REG_CFG)) begin
				ctrl_q <= write_data[CTRL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= item_d;
			div_s1.dq  <= elapsed;
			div_s1.rem <= '0;
		end
	end

	assign s_valid = valid_s1;
	assign s_item  = item_s1;
	assign s_div   = div_s1;

	`CMT_ASSERT(a_time_valid_sticks, time_valid_q |=> time_valid_q, "timestamp valid flag dropped")
	`CMT_ASSERT(a_last_time_on_tick, (last_time_q != $past(last_time_q)) |-> $past(accept && (operation == OP_TICK)), "last timestamp moved without an accepted tick")

endmodule

FILE: rtl/cmt_div_stage.sv
// One pipeline stage of the digit-wise divide of elapsed time by the tick period.
`timescale 1ns / 1ps
module cmt_div_stage import cmt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  div_t  in_div,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item,
	output div_t  out_div
);

	logic                     valid_s1;
	item_t                    item_s1;
	div_t                     div_s1;
	div_t                     div_d;
	logic [TRIAL_W-1:0]       t;
	logic [PROD_W-1:0]        prod;
	logic [DIV_STEP_BITS-1:0] q;
	logic [TRIAL_W-1:0]       back;
	logic [TRIAL_W-1:0]       diff;

	assign in_ready = !valid_s1 || out_ready;

	// The remainder stays below the divisor, so the quotient digit fits in DIV_STEP_BITS.
	always_comb begin
		t    = {in_div.rem, in_div.dq[TIME_W-1 -: DIV_STEP_BITS]};
		prod = PROD_W'(t) * PROD_W'(TICK_RECIP);
		q    = prod[RECIP_SHIFT +: DIV_STEP_BITS];
		back = TRIAL_W'(q) * TICK_TRIAL;
		diff = t - back;
		div_d.dq  = {in_div.dq[TIME_W-DIV_STEP_BITS-1:0], q};
		div_d.rem = diff[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
			div_s1  <= div_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;
	assign out_div   = div_s1;

endmodule

FILE: rtl/cmt_count.sv
// Counter stage: holds the 64-bit count and adds the quotient of each advancing tick.
`timescale 1ns / 1ps
`include "compare_match_timer_regs_assert.svh"
module cmt_count import cmt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             in_item,
	input  logic [TIME_W-1:0] in_quot,
	output logic              out_valid,
	input  logic              out_ready,
	output item_t             out_item,
	output logic [TIME_W-1:0] out_count
);

	logic              move;
	logic [TIME_W-1:0] count_q;
	logic [TIME_W-1:0] count_next;
	logic              valid_s1;
	item_t             item_s1;
	logic [TIME_W-1:0] count_s1;
	item_t             item_d;

	assign in_ready   = !valid_s1 || out_ready;
	assign move       = in_valid && in_ready;
	assign count_next = count_q + in_quot;

	always_comb begin
		item_d = in_item;
		if (in_item.op == OP_READ) begin
			case (in_item.idx)
				REG_CNT_LO: item_d.rd = count_q[REG_W-1:0];
				REG_CNT_HI: item_d.rd = count_q[TIME_W-1:REG_W];
				default:    item_d.rd = in_item.rd;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (move && in_item.adv) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			item_s1  <= item_d;
			count_s1 <= count_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;
	assign out_count = count_s1;

	`CMT_ASSERT(a_count_on_advance, (count_q != $past(count_q)) |-> $past(move && in_item.adv), "counter moved without an advancing tick")

endmodule

FILE: rtl/cmt_match.sv
// Match stage: compare registers, match flags, interrupt enables and the result register.
`timescale 1ns / 1ps
`include "compare_match_timer_regs_assert.svh"
module cmt_match import cmt_pkg::*; #(
	parameter int unsigned NUM_COMPARATORS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             in_item,
	input  logic [TIME_W-1:0] in_count,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [REG_W-1:0]  read_data,
	output logic [FLAG_W-1:0] int_status
);

	logic              move;
	logic              is_cmp;
	logic [IDX_W-1:0]  cmp_off;
	logic [REG_W-1:0]  rd;
	logic [FLAG_W-1:0] flags_q;
	logic [FLAG_W-1:0] flags_d;
	logic [FLAG_W-1:0] irq_en_q;
	logic [FLAG_W-1:0] irq_en_d;
	logic [TIME_W-1:0] cmp_q [NUM_COMPARATORS];
	logic [TIME_W-1:0] cmp_d [NUM_COMPARATORS];
	logic              out_valid_q;
	logic [REG_W-1:0]  read_data_q;
	logic [FLAG_W-1:0] int_status_q;

	assign in_ready = !out_valid_q || out_ready;
	assign move     = in_valid && in_ready;
	assign cmp_off  = in_item.idx - IDX_W'(REG_CMP0_LO);
	assign is_cmp   = in_item.idx inside {[REG_CMP0_LO:REG_CMP3_HI]};

	always_comb begin
		flags_d  = flags_q;
		irq_en_d = irq_en_q;
		cmp_d    = cmp_q;
		rd       = in_item.rd;
		case (in_item.op)
			OP_TICK: begin
				// Armed compare values that the new count has reached fire once and disarm.
				if (in_item.adv) begin
					for (int k = 0; k < NUM_COMPARATORS; k++) begin
						if ((cmp_q[k] != CMP_DISARMED) && (in_count >= cmp_q[k])) begin
							flags_d[k] = 1'b1;
							cmp_d[k]   = CMP_DISARMED;
						end
					end
				end
			end
			OP_READ: begin
				case (in_item.idx)
					REG_INT_STAT: rd = REG_W'(flags_q);
					REG_INT_EN:   rd = REG_W'(irq_en_q);
					REG_STAT:     rd = '0;
					default:      rd = in_item.rd;
				endcase
				if (is_cmp) begin
					for (int k = 0; k < NUM_COMPARATORS; k++) begin
						if (cmp_off[2:1] == 2'(k)) begin
							rd = cmp_off[0] ? cmp_q[k][TIME_W-1:REG_W] : cmp_q[k][REG_W-1:0];
						end
					end
				end
			end
			OP_WRITE: begin
				case (in_item.idx)
					REG_INT_STAT: flags_d  = flags_q & ~in_item.data[FLAG_W-1:0];
					REG_INT_EN:   irq_en_d = in_item.data[FLAG_W-1:0];
					default:      irq_en_d = irq_en_q;
				endcase
				if (is_cmp) begin
					for (int k = 0; k < NUM_COMPARATORS; k++) begin
						if (cmp_off[2:1] == 2'(k)) begin
							if (cmp_off[0]) begin
								cmp_d[k][TIME_W-1:REG_W] = in_item.data;
							end else begin
								cmp_d[k][REG_W-1:0] = in_item.data;
							end
						end
					end
				end
			end
			default: begin
				rd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			irq_en_q <= '0;
			for (int k = 0; k < NUM_COMPARATORS; k++) begin
				cmp_q[k] <= CMP_DISARMED;
			end
		end else if (move) begin
			flags_q  <= flags_d;
			irq_en_q <= irq_en_d;
			cmp_q    <= cmp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			read_data_q  <= rd;
			int_status_q <= flags_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign int_status = int_status_q;

	`CMT_ASSERT(a_flag_rise_on_tick, ((flags_q & ~$past(flags_q)) != '0) |-> $past(move && (in_item.op == OP_TICK) && in_item.adv), "match flag set without an advancing tick")
	`CMT_ASSERT(a_unused_flags_zero, (flags_q >> NUM_COMPARATORS) == '0, "flag set for an absent comparator")

endmodule

FILE: rtl/compare_match_timer_regs.sv
// Top level of the 64-bit timer with compare-match flags and its register port.
`timescale 1ns / 1ps
// Usage:
// Each input item is a time tick (now_ns in nanoseconds), a register read or a register
// write, selected by operation and reg_index. Every item gives exactly one result item:
// read_data holds the value of a read and zero otherwise, int_status holds the compare
// match flags as they stand after the item.
// Both channels are valid/ready. While out_ready stays high a new item can be accepted in
// every clock cycle, so the sustained rate is one item per cycle. Each accepted item passes
// through one front stage that decides the tick and updates the timestamp and config,
// four divide stages that turn elapsed nanoseconds into microseconds sixteen quotient bits
// at a time, one stage that adds to the counter, and the compare stage that writes the
// result register. Up to 7 items can be in flight.
// After reset the counter is zero, counting is enabled, no timestamp has been seen, all
// flags and interrupt enables are clear and every compare register is all ones (disarmed).
// When the receiver stalls, items keep moving into empty stages behind the waiting result,
// and in_ready only drops once every stage holds an item. Results are never dropped.
module compare_match_timer_regs import cmt_pkg::*; #(
	parameter int unsigned NUM_COMPARATORS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   operation,
	input  logic [IDX_W-1:0]  reg_index,
	input  logic [REG_W-1:0]  write_data,
	input  logic [TIME_W-1:0] now_ns,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [REG_W-1:0]  read_data,
	output logic [FLAG_W-1:0] int_status
);

	// Handshake and payload between the divide stages; entry 0 comes from the front stage.
	logic  div_valid [DIV_STAGES+1];
	logic  div_ready [DIV_STAGES+1];
	item_t div_item  [DIV_STAGES+1];
	div_t  div_data  [DIV_STAGES+1];

	logic              cnt_valid;
	logic              cnt_ready;
	item_t             cnt_item;
	logic [TIME_W-1:0] cnt_count;

	cmt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.reg_index  (reg_index),
		.write_data (write_data),
		.now_ns     (now_ns),
		.s_valid    (div_valid[0]),
		.s_ready    (div_ready[0]),
		.s_item     (div_item[0]),
		.s_div      (div_data[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		cmt_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[g]),
			.in_ready  (div_ready[g]),
			.in_item   (div_item[g]),
			.in_div    (div_data[g]),
			.out_valid (div_valid[g+1]),
			.out_ready (div_ready[g+1]),
			.out_item  (div_item[g+1]),
			.out_div   (div_data[g+1])
		);
	end

	// After the last divide stage the shift register holds the whole quotient.
	cmt_count u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid[DIV_STAGES]),
		.in_ready  (div_ready[DIV_STAGES]),
		.in_item   (div_item[DIV_STAGES]),
		.in_quot   (div_data[DIV_STAGES].dq),
		.out_valid (cnt_valid),
		.out_ready (cnt_ready),
		.out_item  (cnt_item),
		.out_count (cnt_count)
	);

	cmt_match #(
		.NUM_COMPARATORS (NUM_COMPARATORS)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cnt_valid),
		.in_ready   (cnt_ready),
		.in_item    (cnt_item),
		.in_count   (cnt_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.int_status (int_status)
	);

endmodule
